@@ sv/kdf_pkg.sv @@
// ----------------------------------------------------------------------------
// kdf_pkg
// Shared widths, register codes and types of the scalar Kalman distance filter.
// ----------------------------------------------------------------------------
package kdf_pkg;

  // payload widths
  localparam int MEAS_W  = 16;
  localparam int DIST_W  = 24;
  localparam int GAIN_W  = 17;
  localparam int COV_W   = 24;

  // low bits of the measurement that take part in the update
  localparam int MEAS_BITS = 16;
  localparam logic [MEAS_W-1:0] MeasMask =
    (MEAS_BITS >= MEAS_W) ? {MEAS_W{1'b1}} : MEAS_W'((1 << MEAS_BITS) - 1);

  // covariance plus process noise, and plus measurement noise
  localparam int PT_W  = COV_W + 1;
  localparam int DEN_W = COV_W + 2;

  // serial divider and multipliers run one bit per cycle over the gain
  localparam int DIV_STEPS = GAIN_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] PROCESS_NOISE_RST = 24'd1442;
  localparam logic [CFG_DATA_W-1:0] MEAS_NOISE_RST    = 24'd40436;
  localparam logic [COV_W-1:0]      COV_RST           = 24'd65536;
  localparam logic [GAIN_W-1:0]     GAIN_ONE          = 17'd65536;

  // divider status toward the sequencer
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [GAIN_W-1:0] quot;
  } kdf_div_stat_t;

endpackage

@@ sv/kdf_meas_if.sv @@
// ----------------------------------------------------------------------------
// kdf_meas_if
// Measurement channel: valid/ready handshake with the raw distance.
// ----------------------------------------------------------------------------
interface kdf_meas_if
  import kdf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MEAS_W-1:0] measured_distance;

  modport source (output valid, output measured_distance, input ready);
  modport sink   (input valid, input measured_distance, output ready);
endinterface

@@ sv/kdf_res_if.sv @@
// ----------------------------------------------------------------------------
// kdf_res_if
// Result channel: valid/ready handshake with estimate, gain and covariance.
// ----------------------------------------------------------------------------
interface kdf_res_if
  import kdf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] filtered_distance;
  logic [GAIN_W-1:0] kalman_gain;
  logic [COV_W-1:0]  error_covariance;

  modport source (output valid, output filtered_distance, output kalman_gain,
                  output error_covariance, input ready);
  modport sink   (input valid, input filtered_distance, input kalman_gain,
                  input error_covariance, output ready);
endinterface

@@ sv/scalar_kalman_distance_filter_core.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_distance_filter_core
// One-dimensional fixed-point Kalman filter over distance measurements.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  meas_i  | in  | valid/ready        | measured_distance[15:0]
//  res_o   | out | valid/ready        | filtered_distance[23:0], kalman_gain[16:0],
//          |     |                    | error_covariance[23:0]
//  cfg     | in  | cfg_we_i           | cfg_idx_i[1:0], cfg_data_i[23:0]
//
// One item at a time: a new measurement is accepted only in idle, after the
// previous one has gone through prepare, the divider steps and done, the multiply
// steps and update; the bit-serial gain divider and multipliers set these steps.
// The result is registered; the next item is taken while it waits, and the
// update stage holds while the previous result is not yet transferred.
// Reset zeroes the estimate, sets covariance to one, noise registers to defaults.
// ----------------------------------------------------------------------------
module scalar_kalman_distance_filter_core
  import kdf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  kdf_meas_if.sink              meas_i,
  kdf_res_if.source             res_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  localparam int ACC_W = PT_W + 1;

  logic [2:0]            state_q, state_d;
  logic [CFG_DATA_W-1:0] q_noise_q, r_noise_q;
  logic [DIST_W-1:0]     est_q;
  logic [COV_W-1:0]      cov_q;
  logic [MEAS_W-1:0]     z_q;
  logic [PT_W-1:0]       pt_q;
  logic signed [PT_W-1:0] innov_q;
  logic                  den_zero_q;
  logic [GAIN_W-1:0]     gain_q, k_sh_q, kc_sh_q;
  logic [STEP_W-1:0]     cnt_q;
  logic signed [ACC_W-1:0] hi1_q;
  logic [ACC_W-1:0]      hi2_q;
  logic [GAIN_W-1:0]     lo1_q, lo2_q;
  logic                  out_valid_q;
  logic [DIST_W-1:0]     out_dist_q;
  logic [GAIN_W-1:0]     out_gain_q;
  logic [COV_W-1:0]      out_cov_q;

  logic                  in_xfer, out_xfer, upd_go;
  logic [PT_W-1:0]       pt_d;
  logic [DEN_W-1:0]      den_d;
  logic [GAIN_W-1:0]     gain_d;
  kdf_div_stat_t         div_stat;
  logic signed [ACC_W-1:0] sum1;
  logic [ACC_W-1:0]      sum2;
  logic signed [ACC_W+1:0] delta;
  logic signed [ACC_W+2:0] est_sum;
  logic [ACC_W:0]        cov_full;
  logic [DIST_W-1:0]     est_new;
  logic [COV_W-1:0]      cov_new;

  assign in_xfer  = meas_i.valid & meas_i.ready;
  assign out_xfer = out_valid_q & res_o.ready;
  assign upd_go   = (state_q == ST_UPD) & (~out_valid_q | res_o.ready);
  assign meas_i.ready = (state_q == ST_IDLE);

  // configuration writes, other indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= PROCESS_NOISE_RST;
      r_noise_q <= MEAS_NOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROCESS_NOISE: q_noise_q <= cfg_data_i;
        CFG_MEAS_NOISE:    r_noise_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // predicted covariance and gain denominator
  assign pt_d  = PT_W'(cov_q) + PT_W'(q_noise_q);
  assign den_d = DEN_W'(pt_d) + DEN_W'(r_noise_q);

  kdf_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_PREP),
    .dividend_i (pt_d),
    .divisor_i  (den_d),
    .stat_o     (div_stat)
  );

  // gain: zero for a zero denominator, capped at one
  always_comb begin
    if (den_zero_q) begin
      gain_d = '0;
    end else if (div_stat.quot > GAIN_ONE) begin
      gain_d = GAIN_ONE;
    end else begin
      gain_d = div_stat.quot;
    end
  end

  // shift-add partial sums of gain*innovation and (one-gain)*covariance
  assign sum1 = k_sh_q[0]  ? hi1_q + ACC_W'(innov_q) : hi1_q;
  assign sum2 = kc_sh_q[0] ? hi2_q + ACC_W'(pt_q)    : hi2_q;

  // round half up, move the estimate, clamp both results
  always_comb begin
    delta    = $signed({hi1_q, lo1_q[GAIN_W-1]}) +
               $signed({{(ACC_W+1){1'b0}}, lo1_q[GAIN_W-2]});
    est_sum  = $signed({3'b000, est_q}) + (ACC_W+3)'(delta);
    cov_full = {hi2_q, lo2_q[GAIN_W-1]};
    if (est_sum < 0) begin
      est_new = '0;
    end else if (est_sum > $signed((ACC_W+3)'({DIST_W{1'b1}}))) begin
      est_new = {DIST_W{1'b1}};
    end else begin
      est_new = est_sum[DIST_W-1:0];
    end
    if (cov_full > (ACC_W+1)'({COV_W{1'b1}})) begin
      cov_new = {COV_W{1'b1}};
    end else begin
      cov_new = cov_full[COV_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_MUL;
      ST_MUL:  if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_UPD;
      ST_UPD:  if (upd_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      est_q       <= '0;
      cov_q       <= COV_RST;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV) begin
        cnt_q <= '0;
      end else if (state_q == ST_MUL) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (upd_go) begin
        est_q       <= est_new;
        cov_q       <= cov_new;
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      z_q <= meas_i.measured_distance & MeasMask;
    end
    if (state_q == ST_PREP) begin
      pt_q       <= pt_d;
      den_zero_q <= (den_d == '0);
      innov_q    <= $signed({1'b0, DIST_W'({z_q, 8'h00})}) - $signed({1'b0, est_q});
    end
    if (state_q == ST_DIV && div_stat.done) begin
      gain_q  <= gain_d;
      k_sh_q  <= gain_d;
      kc_sh_q <= GAIN_ONE - gain_d;
      hi1_q   <= '0;
      hi2_q   <= '0;
    end
    if (state_q == ST_MUL) begin
      hi1_q   <= sum1 >>> 1;
      lo1_q   <= {sum1[0], lo1_q[GAIN_W-1:1]};
      hi2_q   <= sum2 >> 1;
      lo2_q   <= {sum2[0], lo2_q[GAIN_W-1:1]};
      k_sh_q  <= k_sh_q >> 1;
      kc_sh_q <= kc_sh_q >> 1;
    end
    if (upd_go) begin
      out_dist_q <= est_new;
      out_gain_q <= gain_q;
      out_cov_q  <= cov_new;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.filtered_distance = out_dist_q;
  assign res_o.kalman_gain       = out_gain_q;
  assign res_o.error_covariance  = out_cov_q;

  // checks on the sequencer and the divider
  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_PREP)
    else $error("accepted measurement did not start an update");

  a_prep_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PREP |=> div_stat.busy)
    else $error("divider not running after prepare");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_i.ready |-> !div_stat.busy)
    else $error("ready while the divider is busy");

endmodule

@@ sv/kdf_serial_div.sv @@
// ----------------------------------------------------------------------------
// kdf_serial_div
// Restoring divider giving floor(dividend * 65536 / divisor), one quotient bit
// per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module kdf_serial_div
  import kdf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PT_W-1:0]  dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output kdf_div_stat_t    stat_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  dvs_q, dvs_d;
  logic [GAIN_W-1:0] quot_q, quot_d;

  logic [DEN_W:0]    trial;
  logic [DEN_W+1:0]  diff;
  logic              qbit;

  // trial subtract: first step uses the dividend as is, later ones shift in zero
  always_comb begin
    trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff  = {1'b0, trial} - {2'b00, dvs_q};
    qbit  = ~diff[DEN_W+1];
  end

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DEN_W'(dividend_i);
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_d = {quot_q[GAIN_W-2:0], qbit};
      if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.quot = quot_q;

endmodule

@@ test/scalar_kalman_distance_filter_core_tb.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_distance_filter_core_tb
// Drives distance measurements through the scalar Kalman filter core under
// several noise settings, with random idle gaps on the measurement side and
// random stalls on the result side. A bit-exact fixed-point model of the
// update predicts estimate, gain and covariance for every accepted
// measurement, and each result transfer is compared against it in order.
// ----------------------------------------------------------------------------
module scalar_kalman_distance_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kdf_pkg::*;

  localparam longint unsigned SAT24 = 64'hFF_FFFF;
  localparam longint unsigned Q16_ONE = 64'(GAIN_ONE);
  localparam logic [CFG_DATA_W-1:0] NOISE_MAX = {CFG_DATA_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int SETTLE_CYCLES = 50;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic [GAIN_W-1:0] gain;
    logic [COV_W-1:0]  cov;
  } kdf_update_t;

  // fixed-point filter model and in-order store of predicted updates
  class kalman_predictor;
    logic [CFG_DATA_W-1:0] q_noise;
    logic [CFG_DATA_W-1:0] r_noise;
    longint unsigned       est;
    longint unsigned       cov;
    kdf_update_t           expected_updates[$];
    int                    errors;

    function new();
      q_noise = PROCESS_NOISE_RST;
      r_noise = MEAS_NOISE_RST;
      est     = 0;
      cov     = 64'(COV_RST);
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PROCESS_NOISE: q_noise = data;
        CFG_MEAS_NOISE:    r_noise = data;
        default: ;
      endcase
    endfunction

    function void predict_update(logic [MEAS_W-1:0] raw);
      longint unsigned z;
      longint unsigned pt;
      longint unsigned den;
      longint unsigned k;
      longint unsigned cov_next;
      longint          innov;
      longint          delta;
      longint          est_next;
      kdf_update_t     upd;
      z   = 64'(raw & MeasMask);
      pt  = cov + 64'(q_noise);
      den = pt + 64'(r_noise);
      k   = 0;
      if (den != 0) k = (pt << 16) / den;
      if (k > Q16_ONE) k = Q16_ONE;
      // innovation step, rounded half up via floor of the biased product
      innov    = longint'(z << 8) - longint'(est);
      delta    = (longint'(k) * innov + 64'sd32768) >>> 16;
      est_next = longint'(est) + delta;
      if (est_next < 0) est_next = 0;
      if (est_next > longint'(SAT24)) est_next = longint'(SAT24);
      est = longint'(est_next);
      // covariance shrink by (1 - k)
      cov_next = ((Q16_ONE - k) * pt) >> 16;
      if (cov_next > SAT24) cov_next = SAT24;
      cov = cov_next;
      upd.distance = est[DIST_W-1:0];
      upd.gain     = k[GAIN_W-1:0];
      upd.cov      = cov[COV_W-1:0];
      expected_updates.push_back(upd);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_update(kdf_update_t got);
      kdf_update_t exp_upd;
      if (expected_updates.size() == 0) begin
        flag($sformatf("result transfer with none pending: dist=%0d gain=%0d cov=%0d",
                       got.distance, got.gain, got.cov));
        return;
      end
      exp_upd = expected_updates.pop_front();
      if (got.distance !== exp_upd.distance || got.gain !== exp_upd.gain ||
          got.cov !== exp_upd.cov)
        flag($sformatf("dist exp %0d got %0d, gain exp %0d got %0d, cov exp %0d got %0d",
                       exp_upd.distance, got.distance, exp_upd.gain, got.gain,
                       exp_upd.cov, got.cov));
    endfunction

    function int pending();
      return expected_updates.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  kdf_meas_if meas ();
  kdf_res_if  res ();

  kalman_predictor model = new();
  int              track;

  scalar_kalman_distance_filter_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .meas_i     (meas),
    .res_o      (res)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // distance trace: a drifting target with sensor noise, plus spikes and junk
  function automatic logic [MEAS_W-1:0] next_distance();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      track = track + $urandom_range(0, 64) - 32;
      if (track < 0) track = 0;
      if (track > 65535) track = 65535;
      v = track + $urandom_range(0, 16) - 8;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return MEAS_W'(v);
    end
    if (r < 88) return MEAS_W'($urandom);
    if (r < 94) return (r[0]) ? {MEAS_W{1'b1}} : '0;
    return MEAS_W'(track ^ (1 << $urandom_range(0, MEAS_W - 1)));
  endfunction

  // one measurement transfer, optionally after an idle gap
  task automatic send_meas(input logic [MEAS_W-1:0] d, input bit hurry);
    int gap;
    gap = hurry ? 0 : idle_len();
    if (gap > 0) begin
      meas.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    meas.valid             <= 1'b1;
    meas.measured_distance <= d;
    do @(posedge clk_i); while (!meas.ready);
    model.predict_update(d);
  endtask

  // wait until every predicted update has been transferred
  task automatic drain();
    @(posedge clk_i);
    while (model.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    model.write_reg(idx, data);
  endtask

  // reprogram both noise registers while idle, optionally poking both spare indexes
  task automatic cfg_apply(input logic [CFG_DATA_W-1:0] q, input logic [CFG_DATA_W-1:0] r,
                           input bit spare);
    cfg_write(CFG_PROCESS_NOISE, q);
    cfg_write(CFG_MEAS_NOISE, r);
    if (spare) begin
      cfg_write(CFG_SPARE_LO, CFG_DATA_W'($urandom));
      cfg_write(CFG_SPARE_HI, NOISE_MAX);
    end
    cfg_we_i <= 1'b0;
  endtask

  // result side: alternating ready runs and stalls
  initial begin
    int  run;
    bit  lvl;
    res.ready <= 1'b0;
    lvl = 1'b0;
    @(posedge rst_ni);
    forever begin
      lvl = ~lvl;
      run = lvl ? (($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) :
                   $urandom_range(1, 8))
                : idle_len();
      repeat (run) begin
        res.ready <= lvl;
        @(posedge clk_i);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    kdf_update_t got;
    if (rst_ni && res.valid && res.ready) begin
      got.distance = res.filtered_distance;
      got.gain     = res.kalman_gain;
      got.cov      = res.error_covariance;
      model.check_update(got);
    end
  end

  // stimulus
  initial begin
    logic [CFG_DATA_W-1:0] q;
    logic [CFG_DATA_W-1:0] r;
    logic [MEAS_W-1:0]     directed_defaults[] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                                                   16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE,
                                                   16'h8000, 16'h7FFF};
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= '0;
    cfg_data_i             <= '0;
    meas.valid             <= 1'b0;
    meas.measured_distance <= '0;
    track = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings with field extremes and alternating bits
    foreach (directed_defaults[i]) send_meas(directed_defaults[i], i[0]);
    meas.valid <= 1'b0;
    drain();

    // directed: tiny measurement noise, huge process noise
    cfg_apply(NOISE_MAX, CFG_DATA_W'(1), 1'b0);
    send_meas(16'hFFFF, 1'b1);
    send_meas(16'h0000, 1'b0);
    send_meas(16'd12345, 1'b1);
    meas.valid <= 1'b0;
    drain();

    // directed: no process noise, huge measurement noise, spare indexes ignored
    cfg_apply('0, NOISE_MAX, 1'b1);
    send_meas(16'hFFFF, 1'b0);
    send_meas(16'h0000, 1'b1);
    send_meas(16'hFFFF, 1'b1);
    send_meas(16'h00FF, 1'b0);
    meas.valid <= 1'b0;
    drain();

    // random phases, first ones at the register extremes
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin q = '0;                r = CFG_DATA_W'(1); end
        1: begin q = NOISE_MAX;         r = NOISE_MAX;      end
        2: begin q = '0;                r = NOISE_MAX;      end
        3: begin q = NOISE_MAX;         r = CFG_DATA_W'(1); end
        4: begin q = PROCESS_NOISE_RST; r = MEAS_NOISE_RST; end
        default: begin
          q = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(0, 8192));
          r = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(1, 24'hFF_FFFF))
                                           : CFG_DATA_W'($urandom_range(1, 200000));
        end
      endcase
      cfg_apply(q, r, $urandom_range(0, 2) == 0);
      track = $urandom_range(0, 65535);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_meas(next_distance(), (ph % 3) == 2);
      meas.valid <= 1'b0;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
